// ----- src/htseq_pkg.sv -----
// package: widths, codes, reset values and conversion constants of the sensor sequencer
`default_nettype none
package htseq_pkg;

	localparam int unsigned CMD_W      = 2;
	localparam int unsigned ACT_W      = 4;
	localparam int unsigned PH_W       = 3;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned ADDR_W     = 7;
	localparam int unsigned TEMP_W     = 12;
	localparam int unsigned RH_W       = 7;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam int unsigned RAW_W      = 2 * BYTE_W;
	localparam int unsigned TSCL_W     = 15;
	localparam int unsigned TMAG_W     = 14;
	localparam int unsigned TQ_W       = 11;
	localparam int unsigned DIV10_W    = 16;
	localparam int unsigned DIV10_SH   = 19;

	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EVENT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

	localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
	localparam logic [ACT_W-1:0] ACT_START      = 4'd1;
	localparam logic [ACT_W-1:0] ACT_START_ACK  = 4'd2;
	localparam logic [ACT_W-1:0] ACT_SEND       = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RX_EN      = 4'd4;
	localparam logic [ACT_W-1:0] ACT_NACK_STOP  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_STOP_SCHED = 4'd6;
	localparam logic [ACT_W-1:0] ACT_DONE       = 4'd7;
	localparam logic [ACT_W-1:0] ACT_ABORT      = 4'd8;

	localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PH_W-1:0] PH_GET_T  = 3'd1;
	localparam logic [PH_W-1:0] PH_GET_H  = 3'd2;
	localparam logic [PH_W-1:0] PH_READ_T = 3'd3;
	localparam logic [PH_W-1:0] PH_READ_H = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CMD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RH_CMD    = 2'd3;

	localparam logic [ADDR_W-1:0] DEV_ADDR_RST = 7'd64;
	localparam logic [BYTE_W-1:0] TEMP_CMD_RST = 8'd243;
	localparam logic [BYTE_W-1:0] RH_CMD_RST   = 8'd245;

	localparam logic [BYTE_W-1:0]  STATUS_MASK = 8'hFC;
	localparam logic [TSCL_W-1:0]  TEMP_SCALE  = 15'd17572;
	localparam logic [15:0]        TEMP_OFFSET = 16'd4685;
	localparam logic [RH_W-1:0]    RH_SCALE    = 7'd125;
	localparam logic [RH_W-1:0]    RH_OFFSET   = 7'd6;
	localparam logic [RH_W-1:0]    RH_MAX      = 7'd100;
	localparam logic [DIV10_W-1:0] DIV10_RECIP = 16'd52429;

	typedef struct packed {
		logic              temp_done;
		logic              rh_done;
		logic [TSCL_W-1:0] temp_scaled;
		logic [RH_W-1:0]   rh_scaled;
	} conv_in_t;

endpackage
`default_nettype wire

// ----- src/htseq_in_if.sv -----
// interface: request and bus event channel
`default_nettype none
interface htseq_in_if import htseq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic              humidity;
	logic              start_sent;
	logic              address_acked;
	logic              transfer_finished;
	logic              byte_received;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, cmd, humidity, start_sent, address_acked,
		transfer_finished, byte_received, rx_byte, input ready);
	modport sink (input valid, cmd, humidity, start_sent, address_acked,
		transfer_finished, byte_received, rx_byte, output ready);
endinterface
`default_nettype wire

// ----- src/htseq_out_if.sv -----
// interface: bus action and measurement result channel
`default_nettype none
interface htseq_out_if import htseq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [BYTE_W-1:0]        tx_byte;
	logic                     arm_timeout;
	logic                     is_humidity;
	logic                     result_valid;
	logic signed [TEMP_W-1:0] temp_tenths;
	logic [RH_W-1:0]          rh_percent;

	modport source (output valid, action, tx_byte, arm_timeout, is_humidity,
		result_valid, temp_tenths, rh_percent, input ready);
	modport sink (input valid, action, tx_byte, arm_timeout, is_humidity,
		result_valid, temp_tenths, rh_percent, output ready);
endinterface
`default_nettype wire

// ----- src/htseq_conv.sv -----
// module: scaled raw words to tenths of a degree and clamped percent humidity
`default_nettype none
module htseq_conv import htseq_pkg::*; (
	input  conv_in_t                 conv_in,
	output logic signed [TEMP_W-1:0] temp_tenths,
	output logic [RH_W-1:0]          rh_percent
);

	logic [15:0]               t_off;
	logic                      t_neg;
	logic [TMAG_W-1:0]         t_mag;
	logic [TMAG_W+DIV10_W-1:0] q_prod;
	logic [TQ_W-1:0]           t_q;
	logic [TEMP_W-1:0]         t_abs;
	logic [RH_W-1:0]           rh_diff;

	// offset removal, then truncating divide by ten on the magnitude
	assign t_off  = {1'b0, conv_in.temp_scaled} - TEMP_OFFSET;
	assign t_neg  = t_off[15];
	assign t_mag  = t_neg ? TMAG_W'(16'd0 - t_off) : t_off[TMAG_W-1:0];
	assign q_prod = {{DIV10_W{1'b0}}, t_mag} * {{TMAG_W{1'b0}}, DIV10_RECIP};
	assign t_q    = q_prod[DIV10_SH+TQ_W-1:DIV10_SH];
	assign t_abs  = {1'b0, t_q};

	assign rh_diff = conv_in.rh_scaled - RH_OFFSET;

	always_comb begin
		temp_tenths = '0;
		rh_percent  = '0;
		if (conv_in.temp_done) begin
			temp_tenths = t_neg ? $signed(TEMP_W'(0) - t_abs) : $signed(t_abs);
		end
		if (conv_in.rh_done) begin
			if (conv_in.rh_scaled < RH_OFFSET) begin
				rh_percent = '0;
			end else if (rh_diff > RH_MAX) begin
				rh_percent = RH_MAX;
			end else begin
				rh_percent = rh_diff;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/humidity_temp_sensor_i2c_sequencer_unit.sv -----
// top level: i2c measurement sequencer for a humidity and temperature sensor
`default_nettype none
// Each accepted item (request, bus event or timeout) gives exactly one result item
// carrying the next bus action. The block is a three-register pipeline: input
// register, a stage holding the decided action and the scaled sensor word, and the
// output register; the sequencing state is updated in the first stage, so a new
// item is accepted every cycle while the output is not stalled, and its result
// passes through the action stage to the output register. The raw-to-unit multiply
// sits in the first stage and the divide by ten and humidity clamp in the second.
// Configuration writes take effect at the next edge and are meant for idle periods;
// writing the enable register sends both measurements back to their command phase.
module humidity_temp_sensor_i2c_sequencer_unit import htseq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	htseq_in_if.sink              req,
	htseq_out_if.source           rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic adv;

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic              hum_s1;
	logic              sb_s1;
	logic              ad_s1;
	logic              btf_s1;
	logic              rxne_s1;
	logic [BYTE_W-1:0] rx_s1;

	logic              enabled_q;
	logic [ADDR_W-1:0] dev_addr_q;
	logic [BYTE_W-1:0] temp_cmd_q;
	logic [BYTE_W-1:0] rh_cmd_q;

	logic [PH_W-1:0]   phase_q;
	logic              t_read_q;
	logic              h_read_q;
	logic              taken_q;
	logic [BYTE_W-1:0] high_q;

	logic [ACT_W-1:0]  act_c;
	logic [BYTE_W-1:0] tx_c;
	logic              arm_c;
	logic              ish_c;
	logic              done_c;
	logic              conv_t_c;
	logic              conv_h_c;
	logic [PH_W-1:0]   phase_d;
	logic              t_read_d;
	logic              h_read_d;
	logic              taken_d;
	logic              load_high;
	logic              ph_hum;

	logic [RAW_W-1:0]        raw;
	logic [RAW_W+TSCL_W-1:0] t_prod;
	logic [RAW_W+RH_W-1:0]   h_prod;

	logic              valid_s2;
	logic [ACT_W-1:0]  act_s2;
	logic [BYTE_W-1:0] tx_s2;
	logic              arm_s2;
	logic              ish_s2;
	logic              done_s2;
	conv_in_t          conv_s2;

	logic signed [TEMP_W-1:0] temp_c;
	logic [RH_W-1:0]          rh_c;

	logic                     out_valid_q;
	logic [ACT_W-1:0]         act_q;
	logic [BYTE_W-1:0]        tx_q;
	logic                     arm_q;
	logic                     ish_q;
	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [RH_W-1:0]          rh_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= req.cmd;
			hum_s1  <= req.humidity;
			sb_s1   <= req.start_sent;
			ad_s1   <= req.address_acked;
			btf_s1  <= req.transfer_finished;
			rxne_s1 <= req.byte_received;
			rx_s1   <= req.rx_byte;
		end
	end

	assign ph_hum = (phase_q == PH_GET_H) || (phase_q == PH_READ_H);

	// sequencing decision for the item in the input register
	always_comb begin
		act_c     = ACT_NONE;
		tx_c      = '0;
		arm_c     = 1'b0;
		ish_c     = 1'b0;
		done_c    = 1'b0;
		conv_t_c  = 1'b0;
		conv_h_c  = 1'b0;
		phase_d   = phase_q;
		t_read_d  = t_read_q;
		h_read_d  = h_read_q;
		taken_d   = taken_q;
		load_high = 1'b0;
		case (cmd_s1)
			CMD_REQUEST: begin
				if (enabled_q) begin
					ish_c = hum_s1;
					arm_c = 1'b1;
					if (hum_s1 ? h_read_q : t_read_q) begin
						taken_d = 1'b0;
						phase_d = hum_s1 ? PH_READ_H : PH_READ_T;
						act_c   = ACT_START_ACK;
					end else begin
						phase_d = hum_s1 ? PH_GET_H : PH_GET_T;
						act_c   = ACT_START;
					end
				end
			end
			CMD_EVENT: begin
				case (phase_q)
					PH_GET_T, PH_GET_H: begin
						if (sb_s1) begin
							act_c = ACT_SEND;
							tx_c  = {dev_addr_q, 1'b0};
							ish_c = ph_hum;
						end else if (ad_s1) begin
							act_c = ACT_SEND;
							tx_c  = ph_hum ? rh_cmd_q : temp_cmd_q;
							ish_c = ph_hum;
						end else if (btf_s1) begin
							act_c   = ACT_STOP_SCHED;
							ish_c   = ph_hum;
							phase_d = PH_IDLE;
							if (ph_hum) begin
								h_read_d = 1'b1;
							end else begin
								t_read_d = 1'b1;
							end
						end
					end
					PH_READ_T, PH_READ_H: begin
						if (sb_s1) begin
							act_c = ACT_SEND;
							tx_c  = {dev_addr_q, 1'b1};
							ish_c = ph_hum;
						end else if (ad_s1) begin
							act_c = ACT_RX_EN;
							ish_c = ph_hum;
						end else if (rxne_s1) begin
							ish_c = ph_hum;
							if (!taken_q) begin
								load_high = 1'b1;
								taken_d   = 1'b1;
								act_c     = ACT_NACK_STOP;
							end else begin
								act_c   = ACT_DONE;
								done_c  = 1'b1;
								phase_d = PH_IDLE;
								if (ph_hum) begin
									conv_h_c = 1'b1;
									h_read_d = 1'b0;
								end else begin
									conv_t_c = 1'b1;
									t_read_d = 1'b0;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
			CMD_TIMEOUT: begin
				act_c   = ACT_ABORT;
				ish_c   = hum_s1;
				phase_d = PH_IDLE;
				if (hum_s1) begin
					h_read_d = 1'b0;
				end else begin
					t_read_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// raw word with the status bits cleared, scaled by the sensor constants
	assign raw    = {high_q, rx_s1 & STATUS_MASK};
	assign t_prod = {{TSCL_W{1'b0}}, raw} * {{RAW_W{1'b0}}, TEMP_SCALE};
	assign h_prod = {{RH_W{1'b0}}, raw} * {{RAW_W{1'b0}}, RH_SCALE};

	// sequencing state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			t_read_q   <= 1'b0;
			h_read_q   <= 1'b0;
			taken_q    <= 1'b0;
			enabled_q  <= 1'b0;
			dev_addr_q <= DEV_ADDR_RST;
			temp_cmd_q <= TEMP_CMD_RST;
			rh_cmd_q   <= RH_CMD_RST;
		end else begin
			if (adv && valid_s1) begin
				phase_q <= phase_d;
				taken_q <= taken_d;
			end
			if (cfg_we && cfg_index == CFG_ENABLED) begin
				t_read_q <= 1'b0;
				h_read_q <= 1'b0;
			end else if (adv && valid_s1) begin
				t_read_q <= t_read_d;
				h_read_q <= h_read_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLED:  enabled_q  <= cfg_wdata[0];
					CFG_DEV_ADDR: dev_addr_q <= cfg_wdata[ADDR_W-1:0];
					CFG_TEMP_CMD: temp_cmd_q <= cfg_wdata[BYTE_W-1:0];
					CFG_RH_CMD:   rh_cmd_q   <= cfg_wdata[BYTE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && load_high) begin
			high_q <= rx_s1;
		end
	end

	// action stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2              <= act_c;
			tx_s2               <= tx_c;
			arm_s2              <= arm_c;
			ish_s2              <= ish_c;
			done_s2             <= done_c;
			conv_s2.temp_done   <= conv_t_c;
			conv_s2.rh_done     <= conv_h_c;
			conv_s2.temp_scaled <= t_prod[RAW_W+TSCL_W-1:RAW_W];
			conv_s2.rh_scaled   <= h_prod[RAW_W+RH_W-1:RAW_W];
		end
	end

	htseq_conv u_conv (
		.conv_in     (conv_s2),
		.temp_tenths (temp_c),
		.rh_percent  (rh_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_q  <= act_s2;
			tx_q   <= tx_s2;
			arm_q  <= arm_s2;
			ish_q  <= ish_s2;
			done_q <= done_s2;
			temp_q <= temp_c;
			rh_q   <= rh_c;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.action       = act_q;
	assign rsp.tx_byte      = tx_q;
	assign rsp.arm_timeout  = arm_q;
	assign rsp.is_humidity  = ish_q;
	assign rsp.result_valid = done_q;
	assign rsp.temp_tenths  = temp_q;
	assign rsp.rh_percent   = rh_q;

`ifndef SYNTHESIS
	a_valid_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> act_q == ACT_DONE)
		else $error("result_valid without done action");

	a_arm_with_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && arm_q |-> act_q == ACT_START || act_q == ACT_START_ACK)
		else $error("timeout armed without a start action");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && done_c |=> phase_q == PH_IDLE)
		else $error("bus phase not idle after done");

	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q))
		else $error("bus phase changed while stalled");

	a_tx_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && act_q != ACT_SEND |-> tx_q == '0)
		else $error("tx byte set without send action");
`endif

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: random and directed checking of the sensor measurement sequencer against a local predictor
`default_nettype none
module testbench import htseq_pkg::*; ();

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned T_SCALE = 17572;
	localparam int T_OFFSET = 4685;
	localparam int unsigned H_SCALE = 125;
	localparam int H_OFFSET = 6;
	localparam int H_MAX = 100;
	localparam logic [BYTE_W-1:0] LOW_STATUS_MASK = 8'hFC;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              humidity;
		logic              start_sent;
		logic              address_acked;
		logic              transfer_finished;
		logic              byte_received;
		logic [BYTE_W-1:0] rx_byte;
	} bus_item_t;

	localparam int unsigned ITEM_W = $bits(bus_item_t);

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic [BYTE_W-1:0]        tx_byte;
		logic                     arm_timeout;
		logic                     is_humidity;
		logic                     result_valid;
		logic signed [TEMP_W-1:0] temp_tenths;
		logic [RH_W-1:0]          rh_percent;
	} bus_action_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	htseq_in_if req_if ();
	htseq_out_if rsp_if ();

	humidity_temp_sensor_i2c_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predictor copy of configuration and sequencing state
	logic              cfg_enabled = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = 7'd64;
	logic [BYTE_W-1:0] cfg_temp_cmd = 8'd243;
	logic [BYTE_W-1:0] cfg_rh_cmd = 8'd245;
	logic [PH_W-1:0]   seq_phase = PH_IDLE;
	logic              temp_read_pending = 1'b0;
	logic              rh_read_pending = 1'b0;
	logic              second_byte = 1'b0;
	logic [BYTE_W-1:0] first_byte = '0;

	bus_item_t bus_inputs[$];
	bus_action_t awaited_actions[$];
	bus_item_t cur_item;
	bus_action_t want;
	logic item_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bus_action_t next_bus_action(bus_item_t it);
		bus_action_t r;
		logic rd;
		logic h;
		logic [RAW_W-1:0] raw;
		int unsigned prod;
		int scaled;
		r = '0;
		case (it.cmd)
			CMD_REQUEST: begin
				if (cfg_enabled) begin
					rd = it.humidity ? rh_read_pending : temp_read_pending;
					r.is_humidity = it.humidity;
					r.arm_timeout = 1'b1;
					if (rd) begin
						second_byte = 1'b0;
						seq_phase = it.humidity ? PH_READ_H : PH_READ_T;
						r.action = ACT_START_ACK;
					end else begin
						seq_phase = it.humidity ? PH_GET_H : PH_GET_T;
						r.action = ACT_START;
					end
				end
			end
			CMD_EVENT: begin
				if (seq_phase == PH_GET_T || seq_phase == PH_GET_H) begin
					h = (seq_phase == PH_GET_H);
					if (it.start_sent) begin
						r.action = ACT_SEND;
						r.tx_byte = {cfg_addr, 1'b0};
						r.is_humidity = h;
					end else if (it.address_acked) begin
						r.action = ACT_SEND;
						r.tx_byte = h ? cfg_rh_cmd : cfg_temp_cmd;
						r.is_humidity = h;
					end else if (it.transfer_finished) begin
						r.action = ACT_STOP_SCHED;
						r.is_humidity = h;
						if (h) rh_read_pending = 1'b1;
						else temp_read_pending = 1'b1;
						seq_phase = PH_IDLE;
					end
				end else if (seq_phase == PH_READ_T || seq_phase == PH_READ_H) begin
					h = (seq_phase == PH_READ_H);
					if (it.start_sent) begin
						r.action = ACT_SEND;
						r.tx_byte = {cfg_addr, 1'b1};
						r.is_humidity = h;
					end else if (it.address_acked) begin
						r.action = ACT_RX_EN;
						r.is_humidity = h;
					end else if (it.byte_received) begin
						r.is_humidity = h;
						if (!second_byte) begin
							first_byte = it.rx_byte;
							second_byte = 1'b1;
							r.action = ACT_NACK_STOP;
						end else begin
							r.action = ACT_DONE;
							r.result_valid = 1'b1;
							raw = {first_byte, it.rx_byte & LOW_STATUS_MASK};
							if (h) begin
								prod = 32'(raw) * H_SCALE;
								scaled = int'(prod >> 16) - H_OFFSET;
								if (scaled < 0) scaled = 0;
								if (scaled > H_MAX) scaled = H_MAX;
								r.rh_percent = scaled[RH_W-1:0];
								rh_read_pending = 1'b0;
							end else begin
								prod = 32'(raw) * T_SCALE;
								scaled = (int'(prod >> 16) - T_OFFSET) / 10;
								r.temp_tenths = scaled[TEMP_W-1:0];
								temp_read_pending = 1'b0;
							end
							seq_phase = PH_IDLE;
						end
					end
				end
			end
			CMD_TIMEOUT: begin
				r.action = ACT_ABORT;
				r.is_humidity = it.humidity;
				seq_phase = PH_IDLE;
				if (it.humidity) rh_read_pending = 1'b0;
				else temp_read_pending = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// request, timeout or unused code; fields without meaning are random
	function automatic bus_item_t control_item(logic [CMD_W-1:0] c, logic hum);
		bus_item_t it;
		it = bus_item_t'(ITEM_W'($urandom));
		it.cmd = c;
		it.humidity = hum;
		return it;
	endfunction

	// bus event whose winning flag is given by level: sb, ad, btf, rxne
	function automatic bus_item_t bus_event(int level, logic [BYTE_W-1:0] rx);
		bus_item_t it;
		it.cmd = CMD_EVENT;
		it.humidity = 1'($urandom_range(1));
		it.rx_byte = rx;
		it.start_sent = (level == 0);
		it.address_acked = (level == 1) || (level < 1 && $urandom_range(1) == 1);
		it.transfer_finished = (level == 2) || $urandom_range(1) == 1;
		it.byte_received = (level == 3) || (level < 3 && $urandom_range(1) == 1);
		return it;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(9);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return BYTE_W'($urandom);
	endfunction

	// command phase then read phase, cut after the given number of items
	task automatic queue_exchange(logic hum, logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
			int steps);
		bus_item_t seq[9];
		seq[0] = control_item(CMD_REQUEST, hum);
		seq[1] = bus_event(0, BYTE_W'($urandom));
		seq[2] = bus_event(1, BYTE_W'($urandom));
		seq[3] = bus_event(2, BYTE_W'($urandom));
		seq[4] = control_item(CMD_REQUEST, hum);
		seq[5] = bus_event(0, BYTE_W'($urandom));
		seq[6] = bus_event(1, BYTE_W'($urandom));
		seq[7] = bus_event(3, hi);
		seq[8] = bus_event(3, lo);
		for (int i = 0; i < steps; i++) bus_inputs.push_back(seq[i]);
	endtask

	task automatic run_random(int n);
		int r;
		while (bus_inputs.size() < n) begin
			r = $urandom_range(99);
			if (r < 60) begin
				queue_exchange(1'($urandom_range(1)), pick_byte(), pick_byte(), 9);
			end else if (r < 80) begin
				queue_exchange(1'($urandom_range(1)), pick_byte(), pick_byte(),
					$urandom_range(1, 8));
				if ($urandom_range(1))
					bus_inputs.push_back(control_item(CMD_TIMEOUT, 1'($urandom_range(1))));
			end else begin
				repeat ($urandom_range(1, 3))
					bus_inputs.push_back(bus_item_t'(ITEM_W'($urandom)));
			end
		end
	endtask

	task automatic wait_idle();
		while (bus_inputs.size() != 0 || req_if.valid || awaited_actions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_ENABLED: begin
				cfg_enabled = data[0];
				temp_read_pending = 1'b0;
				rh_read_pending = 1'b0;
			end
			CFG_DEV_ADDR: cfg_addr = data[ADDR_W-1:0];
			CFG_TEMP_CMD: cfg_temp_cmd = data;
			CFG_RH_CMD: cfg_rh_cmd = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] en, logic [CFG_DATA_W-1:0] addr,
			logic [CFG_DATA_W-1:0] tcmd, logic [CFG_DATA_W-1:0] hcmd);
		wait_idle();
		write_reg(CFG_ENABLED, en);
		write_reg(CFG_DEV_ADDR, addr);
		write_reg(CFG_TEMP_CMD, tcmd);
		write_reg(CFG_RH_CMD, hcmd);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(string name, logic signed [31:0] exp_val,
			logic signed [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatches++;
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || item_taken) begin
			item_taken = 1'b0;
			if (bus_inputs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_item = bus_inputs.pop_front();
				req_if.valid <= 1'b1;
				req_if.cmd <= cur_item.cmd;
				req_if.humidity <= cur_item.humidity;
				req_if.start_sent <= cur_item.start_sent;
				req_if.address_acked <= cur_item.address_acked;
				req_if.transfer_finished <= cur_item.transfer_finished;
				req_if.byte_received <= cur_item.byte_received;
				req_if.rx_byte <= cur_item.rx_byte;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) rsp_if.ready <= 1'b0;
		else rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// prediction on each accepted item
	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready) begin
			awaited_actions.push_back(next_bus_action(cur_item));
			item_taken = 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (awaited_actions.size() == 0) begin
				$error("unexpected result item: action %0d", rsp_if.action);
				mismatches++;
			end else begin
				want = awaited_actions.pop_front();
				check_field("action", 32'(want.action), 32'(rsp_if.action));
				check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_if.tx_byte));
				check_field("arm_timeout", 32'(want.arm_timeout),
					32'(rsp_if.arm_timeout));
				check_field("is_humidity", 32'(want.is_humidity),
					32'(rsp_if.is_humidity));
				check_field("result_valid", 32'(want.result_valid),
					32'(rsp_if.result_valid));
				check_field("temp_tenths", 32'(want.temp_tenths),
					32'(rsp_if.temp_tenths));
				check_field("rh_percent", 32'(want.rh_percent), 32'(rsp_if.rh_percent));
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL humidity_temp_sensor_i2c_sequencer_unit");
		$finish;
	end

	initial begin
		bus_item_t quiet;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_REQUEST;
		req_if.humidity = 1'b0;
		req_if.start_sent = 1'b0;
		req_if.address_acked = 1'b0;
		req_if.transfer_finished = 1'b0;
		req_if.byte_received = 1'b0;
		req_if.rx_byte = '0;
		rsp_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: disabled request, then enable
		bus_inputs.push_back(control_item(CMD_REQUEST, 1'b0));
		wait_idle();
		write_reg(CFG_ENABLED, 8'h01);
		@(negedge clk);
		cfg_we <= 1'b0;
		// event while idle, coldest reading with status bits set
		bus_inputs.push_back(bus_event(0, 8'h5A));
		queue_exchange(1'b0, 8'h00, 8'h03, 9);
		// takeover while busy, event without meaning, timeout
		bus_inputs.push_back(control_item(CMD_REQUEST, 1'b1));
		bus_inputs.push_back(bus_event(0, 8'hA5));
		bus_inputs.push_back(control_item(CMD_REQUEST, 1'b0));
		quiet = '0;
		quiet.cmd = CMD_EVENT;
		bus_inputs.push_back(quiet);
		bus_inputs.push_back(control_item(CMD_TIMEOUT, 1'b0));
		// humidity clamp at the top, unused code, timeout while idle
		queue_exchange(1'b1, 8'hFF, 8'hFF, 9);
		bus_inputs.push_back(control_item(CMD_UNUSED, 1'b1));
		bus_inputs.push_back(control_item(CMD_TIMEOUT, 1'b1));

		set_config(8'h03, 8'hFF, 8'h00, 8'hFF);
		run_random(180);

		set_config(8'h01, 8'h00, 8'hFF, 8'h00);
		send_idle_pct = 83;
		run_random(180);

		set_config(8'hFE, 8'h80, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
		send_idle_pct = 0;
		recv_stall_pct = 83;
		run_random(20);
		set_config(8'h01, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
			CFG_DATA_W'($urandom));
		run_random(170);

		set_config(8'h01, 8'd64, 8'd243, 8'd245);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		run_random(180);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaited_actions.size() == 0)
			$display("PASS humidity_temp_sensor_i2c_sequencer_unit");
		else
			$display("FAIL humidity_temp_sensor_i2c_sequencer_unit");
		$finish;
	end

endmodule
`default_nettype wire

// ----- humidity_temp_sensor_i2c_sequencer_unit.f -----
src/htseq_pkg.sv
src/htseq_in_if.sv
src/htseq_out_if.sv
src/htseq_conv.sv
src/humidity_temp_sensor_i2c_sequencer_unit.sv
sim/testbench.sv
